/* rtl/core/input_autorange_sampler_macros.svh */
// Assertion macros shared by the sampler RTL.
// Each macro expects signals named clk and rst in the including scope.
`ifndef INPUT_AUTORANGE_SAMPLER_MACROS_SVH
`define INPUT_AUTORANGE_SAMPLER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IAS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/ias_pkg.sv */
// Shared types, constants and the range update function of the sampler.
// No dependencies; every sampler module imports this package.
package ias_pkg;

  localparam int PIN_CHANNELS   = 8;
  localparam int COUNT_CHANNELS = 4;
  localparam int CH_W           = 3;
  localparam int CNT_AW         = 2;
  localparam int TYPES_W        = 24;

  localparam logic [CH_W-1:0] LAST_CH = CH_W'(PIN_CHANNELS - 1);

  localparam logic [6:0] RESET_LIMIT = 7'd99;
  localparam logic [6:0] FREQ_LIMIT  = 7'd19;

  localparam logic [1:0] RANGE_X1 = 2'd0;
  localparam logic [1:0] RANGE_X2 = 2'd1;
  localparam logic [1:0] RANGE_X4 = 2'd2;
  localparam logic [1:0] RANGE_X8 = 2'd3;

  localparam logic [1:0] KIND_DISCRETE = 2'd0;
  localparam logic [1:0] KIND_COUNTER  = 2'd1;
  localparam logic [1:0] KIND_FREQ     = 2'd2;

  localparam logic [15:0] BAND_X2_LO = 16'd100;
  localparam logic [15:0] BAND_X4_LO = 16'd200;
  localparam logic [15:0] BAND_X8_LO = 16'd400;
  localparam logic [15:0] BAND_TOP   = 16'd800;
  localparam logic [15:0] X1_ENTER   = 16'd95;
  localparam logic [15:0] X2_ENTER_LO = 16'd105;
  localparam logic [15:0] X2_ENTER_HI = 16'd194;
  localparam logic [15:0] X4_ENTER_LO = 16'd210;
  localparam logic [15:0] X4_ENTER_HI = 16'd388;
  localparam logic [15:0] X8_ENTER_LO = 16'd420;
  localparam logic [15:0] X8_ENTER_HI = 16'd776;

  typedef enum logic [2:0] {
    TYPE_OFF, TYPE_DIRECT, TYPE_OPEN_DOWN, TYPE_OPEN_UP,
    TYPE_VOLTAGE, TYPE_CURRENT, TYPE_COUNTER, TYPE_FREQ
  } chan_type_t;

  typedef struct packed {
    logic [7:0]  pin_levels;
    logic [15:0] count_ch0;
    logic [15:0] count_ch1;
    logic [15:0] count_ch2;
    logic [15:0] count_ch3;
  } tick_item_t;

  typedef struct packed {
    logic [2:0]  channel;
    logic [1:0]  kind;
    logic [15:0] reading;
    logic        changed;
    logic [1:0]  range_code;
    logic        range_switched;
    logic        last;
  } result_item_t;

  typedef struct packed {
    logic [6:0] count;
    logic [6:0] limit;
    logic [1:0] range;
  } cnt_state_t;

  // One channel handed from the sequencer to the update stage.
  typedef struct packed {
    logic [CH_W-1:0] ch;
    chan_type_t      ctype;
    logic            pin;
    logic [15:0]     reading;
  } issue_t;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            sv_we;
    logic [15:0]     sv_data;
    logic            cs_we;
    cnt_state_t      cs_data;
  } mem_wr_t;

  // Candidate result from the update stage toward the result buffer.
  typedef struct packed {
    logic         valid;
    logic         emit;
    logic         eot;
    result_item_t item;
  } cand_t;

  function automatic logic [1:0] next_range(input logic [1:0] r, input logic [15:0] c);
    logic [1:0] n;
    n = r;
    if (c < BAND_X2_LO) begin
      if (r != RANGE_X1 && c < X1_ENTER) n = RANGE_X1;
    end else if (c < BAND_X4_LO) begin
      if (r != RANGE_X2 && c > X2_ENTER_LO && c < X2_ENTER_HI) n = RANGE_X2;
    end else if (c < BAND_X8_LO) begin
      if (r != RANGE_X4 && c > X4_ENTER_LO && c < X4_ENTER_HI) n = RANGE_X4;
    end else if (c < BAND_TOP) begin
      if (r != RANGE_X8 && c > X8_ENTER_LO && c < X8_ENTER_HI) n = RANGE_X8;
    end
    return n;
  endfunction

endpackage

/* rtl/core/ias_state_mem.sv */
// Channel state memories: stored values and counter state, registered read.
// Depends on ias_pkg.
module ias_state_mem
  import ias_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            rd_en,
  input  logic [CH_W-1:0] rd_ch,
  input  mem_wr_t         wr,
  output logic [15:0]     sv_rdata,
  output cnt_state_t      cs_rdata
);

  logic [15:0]               sv_mem [PIN_CHANNELS];
  cnt_state_t                cs_mem [COUNT_CHANNELS];
  logic [PIN_CHANNELS-1:0]   sv_valid;
  logic [COUNT_CHANNELS-1:0] cs_valid;
  logic [15:0]               sv_q;
  cnt_state_t                cs_q;
  logic                      sv_rv;
  logic                      cs_rv;

  // Entries never written read back as their reset values.
  always_ff @(posedge clk) begin
    if (rst) begin
      sv_valid <= '0;
      cs_valid <= '0;
    end else begin
      if (wr.sv_we) sv_valid[wr.ch] <= 1'b1;
      if (wr.cs_we) cs_valid[wr.ch[CNT_AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.sv_we) sv_mem[wr.ch] <= wr.sv_data;
    if (wr.cs_we) cs_mem[wr.ch[CNT_AW-1:0]] <= wr.cs_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      sv_q  <= sv_mem[rd_ch];
      sv_rv <= sv_valid[rd_ch];
      cs_q  <= cs_mem[rd_ch[CNT_AW-1:0]];
      cs_rv <= cs_valid[rd_ch[CNT_AW-1:0]];
    end
  end

  assign sv_rdata = sv_rv ? sv_q : 16'd0;
  assign cs_rdata = cs_rv ? cs_q
                          : cnt_state_t'{count: 7'd0, limit: RESET_LIMIT, range: RANGE_X8};

endmodule

/* rtl/core/ias_update.sv */
// Update stage: holds the channel whose state is being read and computes
// its result and write-back. Depends on ias_pkg.
module ias_update
  import ias_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       issue,
  input  issue_t     iss,
  input  logic [15:0] sv_rdata,
  input  cnt_state_t cs_rdata,
  input  logic       go,
  output logic       s1_free,
  output cand_t      cand,
  output mem_wr_t    wr
);

  logic       s1_valid;
  issue_t     s1;
  logic       is_disc;
  logic       is_cnt;
  logic       lvl;
  logic [7:0] cnt_p1;
  logic       expire;
  logic [1:0] r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (issue) begin
      s1_valid <= 1'b1;
    end else if (go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) s1 <= iss;
  end

  assign s1_free = !s1_valid || go;

  always_comb begin
    is_disc = 1'b0;
    is_cnt  = 1'b0;
    case (s1.ctype) inside
      TYPE_DIRECT, TYPE_OPEN_DOWN, TYPE_OPEN_UP: is_disc = 1'b1;
      TYPE_COUNTER, TYPE_FREQ: is_cnt = (s1.ch < CH_W'(COUNT_CHANNELS));
      default: ;
    endcase
    lvl    = s1.pin ^ (s1.ctype == TYPE_OPEN_DOWN);
    cnt_p1 = {1'b0, cs_rdata.count} + 8'd1;
    expire = cnt_p1 > {1'b0, cs_rdata.limit};
    r1     = next_range(cs_rdata.range, s1.reading);

    cand.valid = s1_valid;
    cand.eot   = (s1.ch == LAST_CH);
    cand.emit  = is_disc || (is_cnt && expire);
    cand.item.channel = s1.ch;
    cand.item.last    = 1'b0;
    if (is_disc) begin
      cand.item.kind           = KIND_DISCRETE;
      cand.item.reading        = {15'd0, lvl};
      cand.item.range_code     = RANGE_X1;
      cand.item.range_switched = 1'b0;
    end else begin
      cand.item.kind           = (s1.ctype == TYPE_FREQ) ? KIND_FREQ : KIND_COUNTER;
      cand.item.reading        = s1.reading;
      cand.item.range_code     = r1;
      cand.item.range_switched = (r1 != cs_rdata.range);
    end
    cand.item.changed = (sv_rdata != cand.item.reading);

    wr.ch      = s1.ch;
    wr.sv_we   = go && cand.emit;
    wr.sv_data = cand.item.reading;
    wr.cs_we   = go && is_cnt;
    if (expire) begin
      wr.cs_data.count = 7'd0;
      wr.cs_data.limit = (s1.ctype == TYPE_FREQ) ? FREQ_LIMIT : cs_rdata.limit;
      wr.cs_data.range = r1;
    end else begin
      wr.cs_data.count = cnt_p1[6:0];
      wr.cs_data.limit = cs_rdata.limit;
      wr.cs_data.range = cs_rdata.range;
    end
  end

endmodule

/* rtl/core/ias_result_buf.sv */
// Result buffer: holds one result until the next one or the end of the tick
// tells whether it is the last, then drives the output register. Uses ias_pkg.
module ias_result_buf
  import ias_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  cand_t        cand,
  input  logic         result_stall,
  output logic         go,
  output logic         result_valid,
  output result_item_t result
);

  logic         h_valid;
  logic         h_done;
  result_item_t h_item;
  result_item_t h_out;
  logic         out_free;
  logic         push;

  assign out_free = !result_valid || !result_stall;
  assign push     = h_valid && out_free && (h_done || (cand.valid && cand.emit));
  assign go       = cand.valid && (!cand.emit || !h_valid || push);

  always_comb begin
    h_out      = h_item;
    h_out.last = h_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid      <= 1'b0;
      h_done       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (push) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (go && cand.emit) begin
        h_valid <= 1'b1;
        h_done  <= cand.eot;
      end else if (push) begin
        h_valid <= 1'b0;
      end else if (go && cand.eot && h_valid) begin
        h_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && cand.emit) h_item <= cand.item;
    if (push) result <= h_out;
  end

endmodule

/* rtl/core/input_autorange_sampler.sv */
// Top level of the input sampler with counter autoranging.
// Depends on ias_pkg, ias_state_mem, ias_update, ias_result_buf and the macro header.
`include "input_autorange_sampler_macros.svh"

// Usage:
// The tick channel (tick_valid, tick_stall, tick) carries one transaction per
// slow tick: the eight pin levels and the four timer readings. The result
// channel (result_valid, result_stall, result) returns one transaction per
// discrete channel and each expired timer channel, in ascending channel order,
// with last set on the final one of the tick. A tick with no result returns nothing.
// The channel types register is written through cfg_we and cfg_data; the user must
// write it only while the block is idle, as the block does not enforce this.
// Each tick is walked channel by channel, one channel per cycle while the
// update stage has room, through the state memories; a new tick is taken in
// the same cycle as the last channel of the previous one. Each result passes
// through the memory read and update stage registers, the result buffer and
// the output register.
// Reset clears the types register and marks all channel state as at reset
// (interval count 0, limit 99, range x8, stored values 0); no clearing pass.
// A stalled result freezes the update stage once its buffer fills, which in
// turn holds the sequencer and raises tick_stall; nothing is dropped.
module input_autorange_sampler
  import ias_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               tick_valid,
  output logic               tick_stall,
  input  tick_item_t         tick,
  output logic               result_valid,
  input  logic               result_stall,
  output result_item_t       result,
  input  logic               cfg_we,
  input  logic [TYPES_W-1:0] cfg_data
);

  logic [TYPES_W-1:0] channel_types;
  tick_item_t         tick_q;
  logic               t_busy;
  logic [CH_W-1:0]    ch;
  logic               issue;
  logic               s1_free;
  logic               go;
  issue_t             iss;
  mem_wr_t            wr;
  logic [15:0]        sv_rdata;
  cnt_state_t         cs_rdata;
  cand_t              cand;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_types <= '0;
    end else if (cfg_we) begin
      channel_types <= cfg_data;
    end
  end

  // The sequencer issues one channel read per cycle while the update stage
  // has room. A new tick is accepted when the sequencer is free or issuing
  // its last channel.
  assign issue      = t_busy && s1_free;
  assign tick_stall = t_busy && !(issue && ch == LAST_CH);

  always_ff @(posedge clk) begin
    if (rst) begin
      t_busy <= 1'b0;
      ch     <= '0;
    end else if (tick_valid && !tick_stall) begin
      t_busy <= 1'b1;
      ch     <= '0;
    end else if (issue) begin
      if (ch == LAST_CH) t_busy <= 1'b0;
      ch <= ch + CH_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (tick_valid && !tick_stall) tick_q <= tick;
  end

  always_comb begin
    iss.ch    = ch;
    iss.ctype = chan_type_t'(channel_types[ch * 3 +: 3]);
    iss.pin   = tick_q.pin_levels[ch];
    case (ch[CNT_AW-1:0])
      2'd0:    iss.reading = tick_q.count_ch0;
      2'd1:    iss.reading = tick_q.count_ch1;
      2'd2:    iss.reading = tick_q.count_ch2;
      default: iss.reading = tick_q.count_ch3;
    endcase
  end

  ias_state_mem u_mem (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (issue),
    .rd_ch    (ch),
    .wr       (wr),
    .sv_rdata (sv_rdata),
    .cs_rdata (cs_rdata)
  );

  ias_update u_upd (
    .clk      (clk),
    .rst      (rst),
    .issue    (issue),
    .iss      (iss),
    .sv_rdata (sv_rdata),
    .cs_rdata (cs_rdata),
    .go       (go),
    .s1_free  (s1_free),
    .cand     (cand),
    .wr       (wr)
  );

  ias_result_buf u_buf (
    .clk          (clk),
    .rst          (rst),
    .cand         (cand),
    .result_stall (result_stall),
    .go           (go),
    .result_valid (result_valid),
    .result       (result)
  );

  // A write-back never targets the entry being read in the same cycle, so
  // the memories need no forwarding path.
  `IAS_ASSERT_NOW(a_no_rw_clash, issue && (wr.sv_we || wr.cs_we), wr.ch != ch, "read and write hit the same channel")
  // Counter state exists only for channels with a timer.
  `IAS_ASSERT_NOW(a_cs_range, wr.cs_we, wr.ch < CH_W'(COUNT_CHANNELS), "counter state written for a channel without a timer")
  // The interval count never passes the largest limit.
  `IAS_ASSERT_NOW(a_count_bound, wr.cs_we, wr.cs_data.count <= RESET_LIMIT, "interval count beyond its limit")

endmodule
